@@ sv/dif_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dif_pkg;

  // Number of cells in the symbol chain: the longest run plus one spare
  // position behind a symbol that is still waiting at the output.
  localparam int unsigned NCELL      = 48;
  // Bus symbols taken by one byte: eight data bits and the acknowledge slot.
  localparam int unsigned BYTE_SLOTS = 9;
  // Largest number of bytes in one run (set position).
  localparam int unsigned MAX_BYTES  = 5;

  // Second header byte and the set position offsets.
  localparam logic [7:0] HDR_DATA  = 8'h40;
  localparam logic [7:0] HDR_CMD   = 8'h00;
  localparam logic [7:0] PAGE_BASE = 8'hB0;
  localparam logic [7:0] COL_HI_OR = 8'h10;
  localparam logic [7:0] COL_LO_OR = 8'h01;

  typedef enum logic [1:0] {
    CMD_DATA   = 2'd0,
    CMD_SINGLE = 2'd1,
    CMD_POS    = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    SYM_START = 2'd0,
    SYM_BIT   = 2'd1,
    SYM_ACK   = 2'd2,
    SYM_STOP  = 2'd3
  } sym_e;

  // Contents of one chain cell: one bus symbol.
  typedef struct packed {
    logic valid;
    sym_e symbol;
    logic bit_value;
    logic last;
  } cell_t;

  // Per-cell control from the chain controller.
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  // Description of the run caused by one input item.
  typedef struct packed {
    logic                         has_start;
    logic                         has_stop;
    logic [2:0]                   nbytes;
    logic [5:0]                   total;
    logic [MAX_BYTES-1:0][7:0]    bytes;
  } frame_t;

  // Symbol at one position of a run. The caller works out which byte (k)
  // and which slot within that byte (p) the position falls on; lead marks
  // the position taken by the start condition.
  function automatic cell_t slot_cell(input frame_t f, input logic lead,
                                      input int unsigned k, input int unsigned p,
                                      input logic [5:0] pos1);
    cell_t       c;
    int unsigned ki;
    ki = (k < MAX_BYTES) ? k : 0;
    c = '0;
    c.symbol = SYM_START;
    if (lead) begin
      c.valid = 1'b1;
    end else if (k < 32'(f.nbytes)) begin
      c.valid = 1'b1;
      if (p < 8) begin
        c.symbol    = SYM_BIT;
        c.bit_value = f.bytes[3'(ki)][3'(7 - p)];
      end else begin
        c.symbol = SYM_ACK;
      end
    end else if ((k == 32'(f.nbytes)) && (p == 0) && f.has_stop) begin
      c.valid  = 1'b1;
      c.symbol = SYM_STOP;
    end
    c.last = c.valid && (f.total == pos1);
    return c;
  endfunction

endpackage

`default_nettype wire

@@ sv/dif_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one bus operation per transfer.
interface dif_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] value;
  logic [7:0] column;
  logic [3:0] page;
  logic       burst_first;
  logic       burst_last;

  modport source (
    output valid, cmd, value, column, page, burst_first, burst_last,
    input  ready
  );
  modport sink (
    input  valid, cmd, value, column, page, burst_first, burst_last,
    output ready
  );
endinterface

`default_nettype wire

@@ sv/dif_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Symbol channel: one bus symbol per transfer.
interface dif_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] symbol;
  logic       bit_value;
  logic       run_last;

  modport source (
    output valid, symbol, bit_value, run_last,
    input  ready
  );
  modport sink (
    input  valid, symbol, bit_value, run_last,
    output ready
  );
endinterface

`default_nettype wire

@@ sv/display_i2c_write_framer_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Write-only I2C framer for a display controller that never acknowledges.
// in_ch carries one request per transfer (data byte in a burst, single
// command, or set page and column); out_ch carries the resulting bus
// symbols (start, data bit, acknowledge slot, stop), one per transfer,
// with run_last set on the final symbol of each request. cfg_we/cfg_wdata
// write the device address byte sent after every start.
// A request is expanded into a row of 48 cells; the row shifts one
// symbol toward the output per cycle while out_ch is not stalled, and
// cell 0 is the output register, so the first symbol appears the cycle
// after the transfer unless cell 0 still holds a stalled symbol.
// A run is 9 to 47 symbols and leaves at one symbol per cycle while
// out_ch is ready. The next request is taken as soon as only the final
// symbol of the previous run is left, so runs follow each other without
// gaps. A request with the unused selector is taken and produces nothing.
// When out_ch stalls, the whole row holds; a request may still be taken
// behind a stalled final symbol. Reset empties the row and clears the
// address to zero.
module display_i2c_write_framer_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  dif_in_if.sink          in_ch,
  dif_out_if.source       out_ch,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata
);

  logic [7:0]         dev_addr_r;
  dif_pkg::frame_t    frame;
  dif_pkg::cell_t     slot [dif_pkg::NCELL];
  dif_pkg::cell_t     cells [dif_pkg::NCELL];
  logic               tail_busy;
  logic               advance;
  logic               accept;

  // Device address register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= 8'h00;
    end else if (cfg_we) begin
      dev_addr_r <= cfg_wdata;
    end
  end

  dif_frame_builder u_frame (
    .dev_addr    (dev_addr_r),
    .cmd         (in_ch.cmd),
    .value       (in_ch.value),
    .column      (in_ch.column),
    .page        (in_ch.page),
    .burst_first (in_ch.burst_first),
    .burst_last  (in_ch.burst_last),
    .frame       (frame)
  );

  // Symbol for each run position, for runs with and without a start.
  for (genvar i = 0; i < dif_pkg::NCELL; i++) begin : g_slot
    localparam int unsigned K0 = i / dif_pkg::BYTE_SLOTS;
    localparam int unsigned P0 = i % dif_pkg::BYTE_SLOTS;
    localparam int unsigned J1 = (i == 0) ? 0 : i - 1;
    localparam int unsigned K1 = J1 / dif_pkg::BYTE_SLOTS;
    localparam int unsigned P1 = J1 % dif_pkg::BYTE_SLOTS;
    dif_pkg::cell_t s0;
    dif_pkg::cell_t s1;
    always_comb begin
      s0 = dif_pkg::slot_cell(frame, 1'b0, K0, P0, 6'(i + 1));
      s1 = dif_pkg::slot_cell(frame, (i == 0), K1, P1, 6'(i + 1));
      slot[i] = frame.has_start ? s1 : s0;
    end
  end

  // The row may take a new run once only cell 0 can still be busy.
  always_comb begin
    tail_busy = 1'b0;
    for (int unsigned i = 1; i < dif_pkg::NCELL; i++) begin
      tail_busy = tail_busy | cells[i].valid;
    end
  end

  assign in_ch.ready = !tail_busy;
  assign accept      = in_ch.valid && !tail_busy;
  assign advance     = !cells[0].valid || out_ch.ready;

  // Chain of cells; a run lands one position further back when the output
  // cell is holding a stalled symbol.
  for (genvar i = 0; i < dif_pkg::NCELL; i++) begin : g_cell
    dif_pkg::cell_ctl_t ctl;
    dif_pkg::cell_t     load_val;
    dif_pkg::cell_t     shift_val;

    always_comb begin
      ctl.load  = accept && ((i != 0) || advance);
      ctl.shift = advance;
    end

    if (i == 0) begin : g_head
      assign load_val = slot[0];
    end else begin : g_body
      assign load_val = advance ? slot[i] : slot[i-1];
    end

    if (i == dif_pkg::NCELL - 1) begin : g_end
      assign shift_val = '0;
    end else begin : g_mid
      assign shift_val = cells[i+1];
    end

    dif_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .load_val  (load_val),
      .shift_val (shift_val),
      .q         (cells[i])
    );
  end

  // Cell 0 drives the symbol channel.
  assign out_ch.valid     = cells[0].valid;
  assign out_ch.symbol    = cells[0].symbol;
  assign out_ch.bit_value = cells[0].bit_value;
  assign out_ch.run_last  = cells[0].last;

endmodule

`default_nettype wire

@@ sv/dif_frame_builder.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Decodes one request into the list of bytes of its run, with its start
// and stop flags and the run length in symbols.
module dif_frame_builder (
  input  wire logic [7:0]      dev_addr,
  input  wire logic [1:0]      cmd,
  input  wire logic [7:0]      value,
  input  wire logic [7:0]      column,
  input  wire logic [3:0]      page,
  input  wire logic            burst_first,
  input  wire logic            burst_last,
  output dif_pkg::frame_t      frame
);

  logic [5:0] byte_syms;

  // Byte list and framing per operation.
  always_comb begin
    frame = '0;
    unique case (dif_pkg::cmd_e'(cmd))
      dif_pkg::CMD_DATA: begin
        frame.has_start = burst_first;
        frame.has_stop  = burst_last;
        if (burst_first) begin
          frame.nbytes   = 3'd3;
          frame.bytes[0] = dev_addr;
          frame.bytes[1] = dif_pkg::HDR_DATA;
          frame.bytes[2] = value;
        end else begin
          frame.nbytes   = 3'd1;
          frame.bytes[0] = value;
        end
      end
      dif_pkg::CMD_SINGLE: begin
        frame.has_start = 1'b1;
        frame.has_stop  = 1'b1;
        frame.nbytes    = 3'd3;
        frame.bytes[0]  = dev_addr;
        frame.bytes[1]  = dif_pkg::HDR_CMD;
        frame.bytes[2]  = value;
      end
      dif_pkg::CMD_POS: begin
        frame.has_start = 1'b1;
        frame.has_stop  = 1'b1;
        frame.nbytes    = 3'd5;
        frame.bytes[0]  = dev_addr;
        frame.bytes[1]  = dif_pkg::HDR_CMD;
        frame.bytes[2]  = dif_pkg::PAGE_BASE + {4'h0, page};
        frame.bytes[3]  = {4'h0, column[7:4]} | dif_pkg::COL_HI_OR;
        frame.bytes[4]  = {4'h0, column[3:0]} | dif_pkg::COL_LO_OR;
      end
      default: begin
        // Unused selector: empty run.
        frame = '0;
      end
    endcase
    // Run length: nine symbols per byte plus start and stop.
    byte_syms   = {frame.nbytes, 3'b000} + {3'b000, frame.nbytes};
    frame.total = byte_syms + {5'd0, frame.has_start} + {5'd0, frame.has_stop};
  end

endmodule

`default_nettype wire

@@ sv/dif_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

// One cell of the symbol chain. It takes a fresh symbol on load, its
// upstream neighbor's symbol on shift, and holds otherwise.
module dif_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dif_pkg::cell_ctl_t ctl,
  input  wire dif_pkg::cell_t     load_val,
  input  wire dif_pkg::cell_t     shift_val,
  output dif_pkg::cell_t          q
);

  dif_pkg::cell_t cell_r;
  dif_pkg::cell_t cell_nxt;

  // Next content selection.
  always_comb begin
    if (ctl.load) begin
      cell_nxt = load_val;
    end else if (ctl.shift) begin
      cell_nxt = shift_val;
    end else begin
      cell_nxt = cell_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r <= '0;
    end else begin
      cell_r <= cell_nxt;
    end
  end

  assign q = cell_r;

endmodule

`default_nettype wire
